/* rtl/mrqs_pkg.sv */
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler package
// Sizes, command and status codes, datapath operations and shared helpers.
// ----------------------------------------------------------------------------
package mrqs_pkg;

	localparam int CORES       = 4;
	localparam int LEVELS      = 8;
	localparam int QUEUE_DEPTH = 64;

	localparam int CORE_IN_W  = 2;
	localparam int LEVEL_IN_W = 8;
	localparam int ID_W       = 16;
	localparam int STATUS_W   = 3;
	localparam int TOTAL_W    = 10;

	localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_SWITCH  = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_SET_RUN = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEVEL = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_BAD       = 4'd2,
		OP_EMPTY     = 4'd3,
		OP_POP       = 4'd4,
		OP_COMMIT    = 4'd5,
		OP_ADD       = 4'd6,
		OP_SET_RUN   = 4'd7,
		OP_RM_RD     = 4'd8,
		OP_STEP      = 4'd9,
		OP_NOT_FOUND = 4'd10,
		OP_CP_RD     = 4'd11,
		OP_CP_WR     = 4'd12,
		OP_SHRINK    = 4'd13
	} op_t;

	typedef struct packed {
		op_t  op;
		logic idle;
		logic done;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic core_bad;
		logic lvl_bad;
		logic none_ready;
		logic srch_end;
		logic match;
		logic cp_end;
	} dp_stat_t;

	// ring position head + offset, wrapped at the queue depth
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] head,
		input logic [LEN_W-1:0] off);
		logic [LEN_W:0] s;
		s = (LEN_W+1)'(head) + (LEN_W+1)'(off);
		if (s >= (LEN_W+1)'(QUEUE_DEPTH)) begin
			s = s - (LEN_W+1)'(QUEUE_DEPTH);
		end
		return SLOT_W'(s);
	endfunction

endpackage

/* rtl/multilevel_ready_queue_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler unit
// Sequence: add, set running, bad or empty commands pass load, decode and done;
//   a switch adds a pop and a commit; a remove adds a search and a compaction walk.
// Throughput: one command at a time; the search and the compaction walk over the queue
//   memory (one read port, one write port) set the remove cost.
// Reset: all queues empty, served counts zero, no task running on any core.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] core, [17:2] task_id, [25:18] level, [26] outgoing_ends
	input  logic [31:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] next_task, [31:16] prev_task, [32] prev_requeued, [42:33] ready_total
	output logic [47:0] m_tdata,
	// [2:0] status
	output logic [2:0]  m_tuser
);

	mrqs_pkg::ctl_cmd_t ctl;
	mrqs_pkg::dp_stat_t stat;

	logic        out_vld_q;
	logic        out_free;
	logic [2:0]  res_status;
	logic [15:0] res_next;
	logic [15:0] res_prev;
	logic        res_requeued;
	logic [9:0]  res_total;
	logic [42:0] out_data_q;
	logic [2:0]  out_user_q;

	// the result slot frees up on the same edge it is drained
	assign out_free = !out_vld_q || m_tready;

	mrqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.ctl      (ctl)
	);

	mrqs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_cmd       (s_tuser),
		.in_core      (s_tdata[1:0]),
		.in_task_id   (s_tdata[17:2]),
		.in_level     (s_tdata[25:18]),
		.in_ends      (s_tdata[26]),
		.stat         (stat),
		.res_status   (res_status),
		.res_next     (res_next),
		.res_prev     (res_prev),
		.res_requeued (res_requeued),
		.res_total    (res_total)
	);

	// input side takes a transfer whenever the controller is free
	assign s_tready = ctl.idle;

	// output register: hold the result until the master side takes it,
	// so the next command can start meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.done) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			out_data_q <= {res_total, res_requeued, res_prev, res_next};
			out_user_q <= res_status;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_data_q};
	assign m_tuser  = out_user_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |-> out_free)
		else $error("pending result overwritten");

endmodule

/* rtl/mrqs_dpath.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Queue memory, per-level head, length and served counts, running task.
// ----------------------------------------------------------------------------
module mrqs_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mrqs_pkg::ctl_cmd_t                ctl,
	input  logic [1:0]                        in_cmd,
	input  logic [mrqs_pkg::CORE_IN_W-1:0]    in_core,
	input  logic [mrqs_pkg::ID_W-1:0]         in_task_id,
	input  logic [mrqs_pkg::LEVEL_IN_W-1:0]   in_level,
	input  logic                              in_ends,
	output mrqs_pkg::dp_stat_t                stat,
	output logic [mrqs_pkg::STATUS_W-1:0]     res_status,
	output logic [mrqs_pkg::ID_W-1:0]         res_next,
	output logic [mrqs_pkg::ID_W-1:0]         res_prev,
	output logic                              res_requeued,
	output logic [mrqs_pkg::TOTAL_W-1:0]      res_total
);

	localparam int CORES  = mrqs_pkg::CORES;
	localparam int LEVELS = mrqs_pkg::LEVELS;
	localparam int DEPTH  = mrqs_pkg::QUEUE_DEPTH;
	localparam int CORE_W = mrqs_pkg::CORE_W;
	localparam int LVL_W  = mrqs_pkg::LVL_W;
	localparam int SLOT_W = mrqs_pkg::SLOT_W;
	localparam int LEN_W  = mrqs_pkg::LEN_W;
	localparam int ID_W   = mrqs_pkg::ID_W;

	logic [ID_W-1:0] mem [CORES][LEVELS][DEPTH];

	logic [SLOT_W-1:0] head_q   [CORES][LEVELS];
	logic [LEN_W-1:0]  len_q    [CORES][LEVELS];
	logic [LEN_W-1:0]  served_q [CORES][LEVELS];
	logic [ID_W-1:0]   run_task_q [CORES];
	logic [LVL_W-1:0]  run_lvl_q  [CORES];
	logic              run_vld_q  [CORES];

	logic [1:0]                        cmd_q;
	logic [mrqs_pkg::CORE_IN_W-1:0]    core_q;
	logic [ID_W-1:0]                   id_q;
	logic [mrqs_pkg::LEVEL_IN_W-1:0]   level_q;
	logic                              ends_q;
	logic [LEN_W-1:0]                  p_q;
	logic [LVL_W-1:0]                  pick_q;
	logic [ID_W-1:0]                   rdata_q;
	mrqs_pkg::status_t                 status_q;
	logic [ID_W-1:0]                   next_q;
	logic [ID_W-1:0]                   prev_q;
	logic                              rq_q;

	logic [CORE_W-1:0] core_i;
	logic [LVL_W-1:0]  lvl_i;
	logic              core_bad;
	logic              lvl_bad;
	logic              any1;
	logic              anyl;
	logic [LVL_W-1:0]  first1;
	logic [LVL_W-1:0]  firstl;
	logic [LVL_W-1:0]  pick;
	logic [mrqs_pkg::TOTAL_W-1:0] total;
	logic [LEN_W-1:0]  len_cur;
	logic [SLOT_W-1:0] head_cur;
	logic [LVL_W-1:0]  rq_lvl;
	logic [LEN_W-1:0]  rq_len;
	logic              rq_ok;
	logic              add_ok;

	logic              we;
	logic              re;
	logic [LVL_W-1:0]  wl;
	logic [SLOT_W-1:0] ws;
	logic [ID_W-1:0]   wd;
	logic [LVL_W-1:0]  rl;
	logic [SLOT_W-1:0] rs;

	assign core_i   = CORE_W'(core_q);
	assign lvl_i    = LVL_W'(level_q);
	assign core_bad = 32'(core_q) >= 32'(CORES);
	assign lvl_bad  = 32'(level_q) >= 32'(LEVELS);
	assign len_cur  = len_q[core_i][lvl_i];
	assign head_cur = head_q[core_i][lvl_i];
	assign rq_lvl   = run_lvl_q[core_i];
	assign rq_len   = len_q[core_i][rq_lvl];
	assign rq_ok    = run_vld_q[core_i] && !ends_q && (rq_len < LEN_W'(DEPTH));
	assign add_ok   = len_cur < LEN_W'(DEPTH);

	// first level with credit left, first nonempty level for the second pass, and the ready total
	always_comb begin
		any1   = 1'b0;
		anyl   = 1'b0;
		first1 = '0;
		firstl = '0;
		total  = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (served_q[core_i][l] < len_q[core_i][l]) begin
				any1   = 1'b1;
				first1 = LVL_W'(l);
			end
			if (len_q[core_i][l] != '0) begin
				anyl   = 1'b1;
				firstl = LVL_W'(l);
			end
			total = total + mrqs_pkg::TOTAL_W'(len_q[core_i][l]);
		end
	end

	assign pick = any1 ? first1 : firstl;

	assign stat.cmd        = mrqs_pkg::cmd_t'(cmd_q);
	assign stat.core_bad   = core_bad;
	assign stat.lvl_bad    = lvl_bad;
	assign stat.none_ready = !anyl;
	assign stat.srch_end   = p_q >= len_cur;
	assign stat.match      = rdata_q == id_q;
	assign stat.cp_end     = ((LEN_W+1)'(p_q) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len_cur);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wl = lvl_i;
		ws = mrqs_pkg::slot_add(head_cur, len_cur);
		wd = id_q;
		rl = lvl_i;
		rs = mrqs_pkg::slot_add(head_cur, p_q);
		case (ctl.op)
			mrqs_pkg::OP_POP: begin
				re = 1'b1;
				rl = pick;
				rs = head_q[core_i][pick];
			end
			mrqs_pkg::OP_COMMIT: begin
				we = rq_ok;
				wl = rq_lvl;
				ws = mrqs_pkg::slot_add(head_q[core_i][rq_lvl], rq_len);
				wd = run_task_q[core_i];
			end
			mrqs_pkg::OP_ADD: begin
				we = add_ok;
			end
			mrqs_pkg::OP_RM_RD: begin
				re = 1'b1;
			end
			mrqs_pkg::OP_CP_RD: begin
				re = 1'b1;
				rs = mrqs_pkg::slot_add(head_cur, p_q + LEN_W'(1));
			end
			mrqs_pkg::OP_CP_WR: begin
				we = 1'b1;
				wd = rdata_q;
			end
			default: begin
			end
		endcase
		if (ctl.op == mrqs_pkg::OP_CP_WR) begin
			ws = mrqs_pkg::slot_add(head_cur, p_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[core_i][wl][ws] <= wd;
		end
		if (re) begin
			rdata_q <= mem[core_i][rl][rs];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CORES; c++) begin
				for (int l = 0; l < LEVELS; l++) begin
					head_q[c][l]   <= '0;
					len_q[c][l]    <= '0;
					served_q[c][l] <= '0;
				end
				run_task_q[c] <= '0;
				run_lvl_q[c]  <= '0;
				run_vld_q[c]  <= 1'b0;
			end
			p_q    <= '0;
			pick_q <= '0;
		end else begin
			case (ctl.op)
				mrqs_pkg::OP_LOAD: begin
					p_q <= '0;
				end
				mrqs_pkg::OP_POP: begin
					for (int l = 0; l < LEVELS; l++) begin
						if (LVL_W'(l) == pick) begin
							served_q[core_i][l] <= any1 ?
								served_q[core_i][l] + LEN_W'(1) : LEN_W'(1);
						end else if (!any1 || LVL_W'(l) < pick) begin
							served_q[core_i][l] <= '0;
						end
					end
					head_q[core_i][pick] <= mrqs_pkg::slot_add(head_q[core_i][pick],
						LEN_W'(1));
					len_q[core_i][pick]  <= len_q[core_i][pick] - LEN_W'(1);
					pick_q <= pick;
				end
				mrqs_pkg::OP_COMMIT: begin
					if (rq_ok) begin
						len_q[core_i][rq_lvl] <= rq_len + LEN_W'(1);
					end
					run_task_q[core_i] <= rdata_q;
					run_lvl_q[core_i]  <= pick_q;
					run_vld_q[core_i]  <= 1'b1;
				end
				mrqs_pkg::OP_ADD: begin
					if (add_ok) begin
						len_q[core_i][lvl_i] <= len_cur + LEN_W'(1);
					end
				end
				mrqs_pkg::OP_SET_RUN: begin
					run_task_q[core_i] <= id_q;
					run_lvl_q[core_i]  <= lvl_i;
					run_vld_q[core_i]  <= 1'b1;
				end
				mrqs_pkg::OP_STEP, mrqs_pkg::OP_CP_WR: begin
					p_q <= p_q + LEN_W'(1);
				end
				mrqs_pkg::OP_SHRINK: begin
					len_q[core_i][lvl_i] <= len_cur - LEN_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			mrqs_pkg::OP_LOAD: begin
				cmd_q    <= in_cmd;
				core_q   <= in_core;
				id_q     <= in_task_id;
				level_q  <= in_level;
				ends_q   <= in_ends;
				status_q <= mrqs_pkg::ST_OK;
				next_q   <= '0;
				prev_q   <= '0;
				rq_q     <= 1'b0;
			end
			mrqs_pkg::OP_BAD:       status_q <= mrqs_pkg::ST_BAD_LEVEL;
			mrqs_pkg::OP_EMPTY:     status_q <= mrqs_pkg::ST_EMPTY;
			mrqs_pkg::OP_NOT_FOUND: status_q <= mrqs_pkg::ST_NOT_FOUND;
			mrqs_pkg::OP_ADD: begin
				if (!add_ok) begin
					status_q <= mrqs_pkg::ST_FULL;
				end
			end
			mrqs_pkg::OP_COMMIT: begin
				next_q <= rdata_q;
				prev_q <= run_vld_q[core_i] ? run_task_q[core_i] : '0;
				rq_q   <= rq_ok;
			end
			default: begin
			end
		endcase
	end

	assign res_status   = status_q;
	assign res_next     = next_q;
	assign res_prev     = prev_q;
	assign res_requeued = rq_q;
	assign res_total    = core_bad ? '0 : total;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == mrqs_pkg::OP_POP |-> len_q[core_i][pick] != '0)
		else $error("pop from an empty level");

endmodule

/* rtl/mrqs_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one command at a time through the datapath.
// ----------------------------------------------------------------------------
module mrqs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  mrqs_pkg::dp_stat_t  stat,
	output mrqs_pkg::ctl_cmd_t  ctl
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DECODE = 9'b000000010,
		S_POP    = 9'b000000100,
		S_COMMIT = 9'b000001000,
		S_RM_RD  = 9'b000010000,
		S_RM_CMP = 9'b000100000,
		S_CP_RD  = 9'b001000000,
		S_CP_WR  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		ctl.op   = mrqs_pkg::OP_NONE;
		ctl.idle = 1'b0;
		ctl.done = 1'b0;
		case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (in_valid) begin
					ctl.op  = mrqs_pkg::OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				if (stat.core_bad) begin
					ctl.op = mrqs_pkg::OP_BAD;
				end else if (stat.cmd == mrqs_pkg::CMD_SWITCH) begin
					if (stat.none_ready) begin
						ctl.op = mrqs_pkg::OP_EMPTY;
					end else begin
						state_d = S_POP;
					end
				end else if (stat.lvl_bad) begin
					ctl.op = mrqs_pkg::OP_BAD;
				end else if (stat.cmd == mrqs_pkg::CMD_ADD) begin
					ctl.op = mrqs_pkg::OP_ADD;
				end else if (stat.cmd == mrqs_pkg::CMD_SET_RUN) begin
					ctl.op = mrqs_pkg::OP_SET_RUN;
				end else begin
					state_d = S_RM_RD;
				end
			end
			S_POP: begin
				ctl.op  = mrqs_pkg::OP_POP;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				ctl.op  = mrqs_pkg::OP_COMMIT;
				state_d = S_DONE;
			end
			S_RM_RD: begin
				if (stat.srch_end) begin
					ctl.op  = mrqs_pkg::OP_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					ctl.op  = mrqs_pkg::OP_RM_RD;
					state_d = S_RM_CMP;
				end
			end
			S_RM_CMP: begin
				if (stat.match) begin
					state_d = S_CP_RD;
				end else begin
					ctl.op  = mrqs_pkg::OP_STEP;
					state_d = S_RM_RD;
				end
			end
			S_CP_RD: begin
				if (stat.cp_end) begin
					ctl.op  = mrqs_pkg::OP_SHRINK;
					state_d = S_DONE;
				end else begin
					ctl.op  = mrqs_pkg::OP_CP_RD;
					state_d = S_CP_WR;
				end
			end
			S_CP_WR: begin
				ctl.op  = mrqs_pkg::OP_CP_WR;
				state_d = S_CP_RD;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RM_CMP |-> $past(state_q) == S_RM_RD)
		else $error("compare without a preceding read");

endmodule

/* tb/multilevel_ready_queue_scheduler_unit_test.sv */
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler unit test
// Drives add, switch, remove and set-running commands over the stream input,
// predicts every result with a behavioral scheduler model and compares the
// results field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_unit_test;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] next_task;
		logic [15:0] prev_task;
		logic        prev_requeued;
		logic [9:0]  ready_total;
	} sched_result_t;

	typedef struct {
		mrqs_pkg::cmd_t cmd;
		logic [1:0]  core;
		logic [15:0] task_id;
		logic [7:0]  level;
		logic        ends;
		logic        has_expect;
		logic [2:0]  exp_status;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	multilevel_ready_queue_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// scheduler shadow state
	logic [15:0] ring_mem [mrqs_pkg::CORES][mrqs_pkg::LEVELS][mrqs_pkg::QUEUE_DEPTH];
	int          ring_head [mrqs_pkg::CORES][mrqs_pkg::LEVELS];
	int          ring_len [mrqs_pkg::CORES][mrqs_pkg::LEVELS];
	int          served [mrqs_pkg::CORES][mrqs_pkg::LEVELS];
	logic [15:0] run_task [mrqs_pkg::CORES];
	int          run_level [mrqs_pkg::CORES];
	logic        run_valid [mrqs_pkg::CORES];

	sched_result_t expected_results [$];
	int            errors = 0;
	int            sent = 0;
	int            checked = 0;
	int            switches_ok = 0;
	int            fulls = 0;
	bit            quiet = 0;
	int            hold_off = 0;
	// known task ids per core/level, for removes that hit
	logic [15:0]   added_ids [mrqs_pkg::CORES][mrqs_pkg::LEVELS][$];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int core_total(int c);
		int t;
		t = 0;
		for (int l = 0; l < mrqs_pkg::LEVELS; l++) t += ring_len[c][l];
		return t;
	endfunction

	function automatic bit push_task(int c, int l, logic [15:0] id);
		if (ring_len[c][l] >= mrqs_pkg::QUEUE_DEPTH) return 0;
		ring_mem[c][l][(ring_head[c][l] + ring_len[c][l]) % mrqs_pkg::QUEUE_DEPTH] = id;
		ring_len[c][l]++;
		return 1;
	endfunction

	// compute the result of one command and advance the shadow state
	function automatic sched_result_t schedule_cmd(mrqs_pkg::cmd_t cmd, logic [1:0] core,
		logic [15:0] id, logic [7:0] lvl, logic ends);
		sched_result_t r;
		int c, p, pick;
		bit found;
		r = '0;
		r.status = mrqs_pkg::ST_OK;
		if (core >= mrqs_pkg::CORES) begin
			r.status = mrqs_pkg::ST_BAD_LEVEL;
			return r;
		end
		c = int'(core);
		if (cmd == mrqs_pkg::CMD_SWITCH) begin
			found = 0;
			pick = 0;
			if (core_total(c) != 0) begin
				for (int pass = 0; pass < 2 && !found; pass++) begin
					for (int l = 0; l < mrqs_pkg::LEVELS; l++) begin
						if (served[c][l] < ring_len[c][l]) begin
							r.next_task = ring_mem[c][l][ring_head[c][l]];
							ring_head[c][l] = (ring_head[c][l] + 1) % mrqs_pkg::QUEUE_DEPTH;
							ring_len[c][l]--;
							served[c][l]++;
							pick = l;
							found = 1;
							break;
						end
						served[c][l] = 0;
					end
				end
			end
			if (found) begin
				if (run_valid[c]) begin
					r.prev_task = run_task[c];
					if (!ends && push_task(c, run_level[c], run_task[c]))
						r.prev_requeued = 1'b1;
				end
				run_task[c] = r.next_task;
				run_level[c] = pick;
				run_valid[c] = 1'b1;
				switches_ok++;
			end else begin
				r.status = mrqs_pkg::ST_EMPTY;
			end
		end else if (lvl >= mrqs_pkg::LEVELS) begin
			r.status = mrqs_pkg::ST_BAD_LEVEL;
		end else if (cmd == mrqs_pkg::CMD_ADD) begin
			if (!push_task(c, int'(lvl), id)) begin
				r.status = mrqs_pkg::ST_FULL;
				fulls++;
			end
		end else if (cmd == mrqs_pkg::CMD_REMOVE) begin
			found = 0;
			for (p = 0; p < ring_len[c][lvl]; p++) begin
				if (ring_mem[c][lvl][(ring_head[c][lvl] + p) % mrqs_pkg::QUEUE_DEPTH] == id)
				begin
					found = 1;
					break;
				end
			end
			if (!found) begin
				r.status = mrqs_pkg::ST_NOT_FOUND;
			end else begin
				// close the gap, keep queue order
				for (int q = p; q + 1 < ring_len[c][lvl]; q++)
					ring_mem[c][lvl][(ring_head[c][lvl] + q) % mrqs_pkg::QUEUE_DEPTH] =
						ring_mem[c][lvl][(ring_head[c][lvl] + q + 1) % mrqs_pkg::QUEUE_DEPTH];
				ring_len[c][lvl]--;
			end
		end else begin
			run_task[c] = id;
			run_level[c] = int'(lvl);
			run_valid[c] = 1'b1;
		end
		r.ready_total = 10'(core_total(c));
		return r;
	endfunction

	// offer one command; predict it when the transfer happens
	task automatic send_cmd(mrqs_pkg::cmd_t cmd, logic [1:0] core, logic [15:0] id,
		logic [7:0] lvl, logic ends);
		sched_result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, ends, lvl, id, core};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = schedule_cmd(cmd, core, id, lvl, ends);
		expected_results.push_back(r);
		if (cmd == mrqs_pkg::CMD_ADD && r.status == mrqs_pkg::ST_OK &&
			core < mrqs_pkg::CORES)
			added_ids[core][lvl].push_back(id);
		sent++;
	endtask

	// drop the offer and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// output side: random stalls, plus the long hold-off when requested
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[32], m_tdata[42:33]};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.next_task !== want.next_task) begin
					$display("%0t: next_task expected %h actual %h", $time, want.next_task,
						got.next_task);
					errors++;
				end
				if (got.prev_task !== want.prev_task) begin
					$display("%0t: prev_task expected %h actual %h", $time, want.prev_task,
						got.prev_task);
					errors++;
				end
				if (got.prev_requeued !== want.prev_requeued) begin
					$display("%0t: prev_requeued expected %b actual %b", $time,
						want.prev_requeued, got.prev_requeued);
					errors++;
				end
				if (got.ready_total !== want.ready_total) begin
					$display("%0t: ready_total expected %0d actual %0d", $time,
						want.ready_total, got.ready_total);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		#40000000;
		$display("multilevel_ready_queue_scheduler_unit test failed");
		$finish;
	end

	cmd_row_t directed [] = '{
		// after reset: nothing ready
		'{mrqs_pkg::CMD_SWITCH,  2'd0, 16'h0000, 8'd0,   1'b0, 1'b1, mrqs_pkg::ST_EMPTY},
		'{mrqs_pkg::CMD_ADD,     2'd0, 16'hFFFF, 8'd255, 1'b0, 1'b1, mrqs_pkg::ST_BAD_LEVEL},
		'{mrqs_pkg::CMD_REMOVE,  2'd1, 16'h0001, 8'd8,   1'b0, 1'b1, mrqs_pkg::ST_BAD_LEVEL},
		'{mrqs_pkg::CMD_SET_RUN, 2'd2, 16'h0001, 8'd128, 1'b0, 1'b1, mrqs_pkg::ST_BAD_LEVEL},
		'{mrqs_pkg::CMD_REMOVE,  2'd0, 16'h1234, 8'd3,   1'b0, 1'b1, mrqs_pkg::ST_NOT_FOUND},
		// no task running: switch with no outgoing task
		'{mrqs_pkg::CMD_ADD,     2'd0, 16'hFFFF, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_ADD,     2'd0, 16'h0000, 8'd7,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_ADD,     2'd0, 16'hAAAA, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd0, 16'h0000, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd0, 16'h5555, 8'd200, 1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd0, 16'h0000, 8'd0,   1'b1, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd0, 16'h0000, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		// remove keeps order: middle entry
		'{mrqs_pkg::CMD_ADD,     2'd3, 16'h0011, 8'd5,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_ADD,     2'd3, 16'h0022, 8'd5,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_ADD,     2'd3, 16'h0033, 8'd5,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_REMOVE,  2'd3, 16'h0022, 8'd5,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SET_RUN, 2'd3, 16'h8001, 8'd7,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd3, 16'h0000, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd3, 16'h0000, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd3, 16'h0000, 8'd0,   1'b1, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd3, 16'h0000, 8'd0,   1'b0, 1'b0, mrqs_pkg::ST_OK},
		'{mrqs_pkg::CMD_SWITCH,  2'd1, 16'h0000, 8'd0,   1'b0, 1'b1, mrqs_pkg::ST_EMPTY}
	};

	initial begin
		int n, c, l, k;
		sched_result_t r;
		mrqs_pkg::cmd_t cmd;
		logic [15:0] id;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = mrqs_pkg::CMD_ADD;
		arst_n   = 1'b0;
		for (int i = 0; i < mrqs_pkg::CORES; i++) begin
			run_task[i] = '0; run_level[i] = 0; run_valid[i] = 1'b0;
			for (int j = 0; j < mrqs_pkg::LEVELS; j++) begin
				ring_head[i][j] = 0; ring_len[i][j] = 0; served[i][j] = 0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; status typed in where obvious, predictor covers the rest
		foreach (directed[i]) begin
			send_cmd(directed[i].cmd, directed[i].core, directed[i].task_id,
				directed[i].level, directed[i].ends);
			if (directed[i].has_expect &&
				expected_results[$].status !== directed[i].exp_status) begin
				$display("%0t: row %0d table status expected %0d predicted %0d", $time, i,
					directed[i].exp_status, expected_results[$].status);
				errors++;
			end
		end

		// fill one queue to the top, then requeue into the full queue
		drain_results();
		send_cmd(mrqs_pkg::CMD_SET_RUN, 2'd2, 16'h7777, 8'd1, 1'b0);
		for (int i = 0; i < mrqs_pkg::QUEUE_DEPTH + 1; i++)
			send_cmd(mrqs_pkg::CMD_ADD, 2'd2, 16'(16'h100 + i), 8'd1, 1'b0);
		send_cmd(mrqs_pkg::CMD_ADD, 2'd2, 16'h0abc, 8'd0, 1'b0);
		send_cmd(mrqs_pkg::CMD_SWITCH, 2'd2, 16'h0, 8'd0, 1'b0);
		send_cmd(mrqs_pkg::CMD_SWITCH, 2'd2, 16'h0, 8'd0, 1'b0);

		// sender pauses until every expected result has come
		drain_results();

		// receiver holds off while the sender keeps offering
		hold_off = 200;
		for (int i = 0; i < 12; i++)
			send_cmd(mrqs_pkg::CMD_ADD, 2'd1, 16'($urandom),
				8'($urandom_range(0, mrqs_pkg::LEVELS - 1)), 1'b0);

		// random part: mostly valid commands that build real queue traffic
		for (n = 0; n < 650; n++) begin
			if (n == 560) quiet = 1;
			c = $urandom_range(0, 3);
			l = $urandom_range(0, mrqs_pkg::LEVELS - 1);
			if ($urandom_range(0, 15) == 0) l = $urandom_range(mrqs_pkg::LEVELS, 255);
			k = $urandom_range(0, 99);
			id = 16'($urandom);
			if (k < 40) cmd = mrqs_pkg::CMD_ADD;
			else if (k < 75) cmd = mrqs_pkg::CMD_SWITCH;
			else if (k < 92) cmd = mrqs_pkg::CMD_REMOVE;
			else cmd = mrqs_pkg::CMD_SET_RUN;
			// removes mostly target an id that was added there
			if (cmd == mrqs_pkg::CMD_REMOVE && l < mrqs_pkg::LEVELS &&
				added_ids[c][l].size() != 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, added_ids[c][l].size() - 1);
				id = added_ids[c][l][k];
				added_ids[c][l].delete(k);
			end
			send_cmd(cmd, 2'(c), id, 8'(l), 1'($urandom));
		end

		drain_results();
		repeat (300) @(posedge clk);
		$display("Sent %0d commands, checked %0d results: %0d switches picked a task,",
			sent, checked, switches_ok);
		$display("%0d adds hit a full queue; remaining expectations %0d",
			fulls, expected_results.size());
		if (errors == 0 && expected_results.size() == 0) begin
			$display("multilevel_ready_queue_scheduler_unit test passed");
		end else begin
			$display("multilevel_ready_queue_scheduler_unit test failed");
		end
		$finish;
	end

endmodule

/* multilevel_ready_queue_scheduler_unit.f */
rtl/mrqs_pkg.sv
rtl/mrqs_dpath.sv
rtl/mrqs_ctrl.sv
rtl/multilevel_ready_queue_scheduler_unit.sv
tb/multilevel_ready_queue_scheduler_unit_test.sv
